### rtl/core/rvdec_pkg.sv
package rvdec_pkg;

  // Major opcodes, instruction bits 6:0
  localparam logic [6:0] OPC_LUI      = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC    = 7'b0010111;
  localparam logic [6:0] OPC_JAL      = 7'b1101111;
  localparam logic [6:0] OPC_JALR     = 7'b1100111;
  localparam logic [6:0] OPC_BRANCH   = 7'b1100011;
  localparam logic [6:0] OPC_LOAD     = 7'b0000011;
  localparam logic [6:0] OPC_STORE    = 7'b0100011;
  localparam logic [6:0] OPC_OP_IMM   = 7'b0010011;
  localparam logic [6:0] OPC_OP       = 7'b0110011;
  localparam logic [6:0] OPC_MISC_MEM = 7'b0001111;
  localparam logic [6:0] OPC_SYSTEM   = 7'b1110011;
  localparam logic [6:0] OPC_LOAD_FP  = 7'b0000111;
  localparam logic [6:0] OPC_STORE_FP = 7'b0100111;
  localparam logic [6:0] OPC_MADD     = 7'b1000011;
  localparam logic [6:0] OPC_MSUB     = 7'b1000111;
  localparam logic [6:0] OPC_NMSUB    = 7'b1001011;
  localparam logic [6:0] OPC_NMADD    = 7'b1001111;
  localparam logic [6:0] OPC_OP_FP    = 7'b1010011;

  // funct7 codes
  localparam logic [6:0] F7_BASE     = 7'b0000000;
  localparam logic [6:0] F7_ALT      = 7'b0100000;
  localparam logic [6:0] F7_FADD_S   = 7'h00;
  localparam logic [6:0] F7_FSUB_S   = 7'h04;
  localparam logic [6:0] F7_FMUL_S   = 7'h08;
  localparam logic [6:0] F7_FDIV_S   = 7'h0C;
  localparam logic [6:0] F7_FSQRT_S  = 7'h2C;
  localparam logic [6:0] F7_FSGNJ_S  = 7'h10;
  localparam logic [6:0] F7_FMINMAX_S = 7'h14;
  localparam logic [6:0] F7_FCVT_W_S = 7'h60;
  localparam logic [6:0] F7_FMV_X_W  = 7'h70;
  localparam logic [6:0] F7_FCMP_S   = 7'h50;
  localparam logic [6:0] F7_FCVT_S_W = 7'h68;
  localparam logic [6:0] F7_FMV_W_X  = 7'h78;
  localparam logic [6:0] F7_FADD_D   = 7'h01;
  localparam logic [6:0] F7_FSUB_D   = 7'h05;
  localparam logic [6:0] F7_FMUL_D   = 7'h09;
  localparam logic [6:0] F7_FDIV_D   = 7'h0D;
  localparam logic [6:0] F7_FSQRT_D  = 7'h2D;
  localparam logic [6:0] F7_FSGNJ_D  = 7'h11;
  localparam logic [6:0] F7_FMINMAX_D = 7'h15;
  localparam logic [6:0] F7_FCVT_S_D = 7'h20;
  localparam logic [6:0] F7_FCVT_D_S = 7'h21;
  localparam logic [6:0] F7_FCMP_D   = 7'h51;
  localparam logic [6:0] F7_FCLASS_D = 7'h71;
  localparam logic [6:0] F7_FCVT_W_D = 7'h61;
  localparam logic [6:0] F7_FCVT_D_W = 7'h69;

  typedef enum logic [2:0] {
    FMT_N  = 3'd0,
    FMT_U  = 3'd1,
    FMT_J  = 3'd2,
    FMT_I  = 3'd3,
    FMT_B  = 3'd4,
    FMT_S  = 3'd5,
    FMT_R  = 3'd6,
    FMT_R4 = 3'd7
  } fmt_t;

  typedef enum logic [6:0] {
    OP_NONE = 7'd0,
    OP_LUI = 7'd1, OP_AUIPC, OP_JAL, OP_JALR,
    OP_BEQ = 7'd5, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
    OP_LB = 7'd11, OP_LH, OP_LW, OP_LBU, OP_LHU,
    OP_SB = 7'd16, OP_SH, OP_SW,
    OP_ADDI = 7'd19, OP_SLTI, OP_SLTIU, OP_XORI, OP_ORI, OP_ANDI,
    OP_SLLI = 7'd25, OP_SRLI, OP_SRAI,
    OP_ADD = 7'd28, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA,
    OP_OR = 7'd36, OP_AND,
    OP_FENCE = 7'd38, OP_FENCE_I, OP_EBREAK, OP_ECALL,
    OP_CSRRW = 7'd42, OP_CSRRS, OP_CSRRC, OP_CSRRWI, OP_CSRRSI, OP_CSRRCI,
    OP_FLW = 7'd48, OP_FLD, OP_FSW, OP_FSD,
    OP_FMADD_D = 7'd52, OP_FMADD_S, OP_FMSUB_D, OP_FMSUB_S,
    OP_FNMSUB_D = 7'd56, OP_FNMSUB_S, OP_FNMADD_D, OP_FNMADD_S,
    OP_FADD_S = 7'd60, OP_FSUB_S, OP_FMUL_S, OP_FDIV_S, OP_FSQRT_S,
    OP_FSGNJ_S = 7'd65, OP_FSGNJN_S, OP_FSGNJX_S, OP_FMIN_S, OP_FMAX_S,
    OP_FCVT_WU_S = 7'd70, OP_FCVT_W_S, OP_FMV_X_W, OP_FCLASS_S,
    OP_FEQ_S = 7'd74, OP_FLT_S, OP_FLE_S,
    OP_FCVT_S_WU = 7'd77, OP_FCVT_S_W, OP_FMV_W_X,
    OP_FADD_D = 7'd80, OP_FSUB_D, OP_FMUL_D, OP_FDIV_D, OP_FSQRT_D,
    OP_FSGNJ_D = 7'd85, OP_FSGNJN_D, OP_FSGNJX_D, OP_FMIN_D, OP_FMAX_D,
    OP_FCVT_S_D = 7'd90, OP_FCVT_D_S,
    OP_FEQ_D = 7'd92, OP_FLT_D, OP_FLE_D, OP_FCLASS_D,
    OP_FCVT_WU_D = 7'd96, OP_FCVT_W_D, OP_FCVT_D_WU, OP_FCVT_D_W
  } op_t;

  localparam int unsigned INSN_W = 32;
  localparam int unsigned OUT_W  = 48;

endpackage

### rtl/core/riscv_instruction_decoder_top.sv
// RV32I/F/D instruction decoder, one request in, one decoded request out.
// m_axis_tvalid rises in the cycle after input accept (single result register).
// Throughput: 1 request per cycle while m_axis_tready is held high; the decode tree is one level of logic
//   in front of the result register, which is also the only storage.
// Reset: rst (sync, active high) clears the result valid; data regs not reset.
module riscv_instruction_decoder_top
  import rvdec_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [INSN_W-1:0]   s_axis_tdata,  // [31:0] instruction_word
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OUT_W-1:0]    m_axis_tdata   // [6:0] operation_index,
                                             // [9:7] format_code,
                                             // [41:10] instruction_echo,
                                             // [47:42] zero
);

  logic        s_fire;
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic        b20;
  logic        dbl;
  op_t         op_next;
  fmt_t        fmt_next;

  // result register
  logic              valid;
  op_t               op;
  fmt_t              fmt;
  logic [INSN_W-1:0] echo;

  // Output register frees up in the same cycle it is drained, so a new
  // request can land every clock while m_axis_tready stays high.
  assign s_axis_tready = !valid || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign opc = s_axis_tdata[6:0];
  assign f3  = s_axis_tdata[14:12];
  assign f7  = s_axis_tdata[31:25];
  assign b20 = s_axis_tdata[20];
  assign dbl = f7[0];  // fused multiply-add: bit 25 picks the D form

  always_comb begin
    op_next  = OP_NONE;
    fmt_next = FMT_N;
    case (opc)
      OPC_LUI: begin
        op_next = OP_LUI; fmt_next = FMT_U;
      end
      OPC_AUIPC: begin
        op_next = OP_AUIPC; fmt_next = FMT_U;
      end
      OPC_JAL: begin
        op_next = OP_JAL; fmt_next = FMT_J;
      end
      OPC_JALR: begin
        op_next = OP_JALR; fmt_next = FMT_I;
      end
      OPC_BRANCH: begin
        fmt_next = FMT_B;
        case (f3)
          3'd0:    op_next = OP_BEQ;
          3'd1:    op_next = OP_BNE;
          3'd4:    op_next = OP_BLT;
          3'd5:    op_next = OP_BGE;
          3'd6:    op_next = OP_BLTU;
          3'd7:    op_next = OP_BGEU;
          default: op_next = OP_NONE;
        endcase
      end
      OPC_LOAD: begin
        fmt_next = FMT_I;
        case (f3)
          3'd0:    op_next = OP_LB;
          3'd1:    op_next = OP_LH;
          3'd2:    op_next = OP_LW;
          3'd4:    op_next = OP_LBU;
          3'd5:    op_next = OP_LHU;
          default: op_next = OP_NONE;
        endcase
      end
      OPC_STORE: begin
        fmt_next = FMT_S;
        case (f3)
          3'd0:    op_next = OP_SB;
          3'd1:    op_next = OP_SH;
          3'd2:    op_next = OP_SW;
          default: op_next = OP_NONE;
        endcase
      end
      OPC_OP_IMM: begin
        fmt_next = FMT_I;
        case (f3)
          3'd0: op_next = OP_ADDI;
          3'd1: op_next = OP_SLLI;  // funct7 not checked
          3'd2: op_next = OP_SLTI;
          3'd3: op_next = OP_SLTIU;
          3'd4: op_next = OP_XORI;
          3'd5: begin
            if (f7 == F7_BASE)     op_next = OP_SRLI;
            else if (f7 == F7_ALT) op_next = OP_SRAI;
            else                   op_next = OP_NONE;
          end
          3'd6:    op_next = OP_ORI;
          default: op_next = OP_ANDI;
        endcase
      end
      OPC_OP: begin
        fmt_next = FMT_R;
        case (f3)
          3'd0: begin
            if (f7 == F7_BASE)     op_next = OP_ADD;
            else if (f7 == F7_ALT) op_next = OP_SUB;
            else                   op_next = OP_NONE;
          end
          3'd1: op_next = OP_SLL;
          3'd2: op_next = OP_SLT;
          3'd3: op_next = OP_SLTU;
          3'd4: op_next = OP_XOR;
          3'd5: begin
            if (f7 == F7_BASE)     op_next = OP_SRL;
            else if (f7 == F7_ALT) op_next = OP_SRA;
            else                   op_next = OP_NONE;
          end
          3'd6:    op_next = OP_OR;
          default: op_next = OP_AND;
        endcase
      end
      OPC_MISC_MEM: begin
        fmt_next = FMT_I;
        case (f3)
          3'd0:    op_next = OP_FENCE;
          3'd1:    op_next = OP_FENCE_I;
          default: op_next = OP_NONE;
        endcase
      end
      OPC_SYSTEM: begin
        fmt_next = FMT_I;
        case (f3)
          3'd0:    op_next = b20 ? OP_EBREAK : OP_ECALL;
          3'd1:    op_next = OP_CSRRW;
          3'd2:    op_next = OP_CSRRS;
          3'd3:    op_next = OP_CSRRC;
          3'd5:    op_next = OP_CSRRWI;
          3'd6:    op_next = OP_CSRRSI;
          3'd7:    op_next = OP_CSRRCI;
          default: op_next = OP_NONE;
        endcase
      end
      OPC_LOAD_FP: begin
        fmt_next = FMT_I;
        case (f3)
          3'd2:    op_next = OP_FLW;
          3'd3:    op_next = OP_FLD;
          default: op_next = OP_NONE;
        endcase
      end
      OPC_STORE_FP: begin
        fmt_next = FMT_S;
        case (f3)
          3'd2:    op_next = OP_FSW;
          3'd3:    op_next = OP_FSD;
          default: op_next = OP_NONE;
        endcase
      end
      OPC_MADD: begin
        op_next = dbl ? OP_FMADD_D : OP_FMADD_S; fmt_next = FMT_R4;
      end
      OPC_MSUB: begin
        op_next = dbl ? OP_FMSUB_D : OP_FMSUB_S; fmt_next = FMT_R4;
      end
      OPC_NMSUB: begin
        op_next = dbl ? OP_FNMSUB_D : OP_FNMSUB_S; fmt_next = FMT_R4;
      end
      OPC_NMADD: begin
        op_next = dbl ? OP_FNMADD_D : OP_FNMADD_S; fmt_next = FMT_R4;
      end
      OPC_OP_FP: begin
        fmt_next = FMT_R;
        case (f7)
          F7_FADD_S:  op_next = OP_FADD_S;
          F7_FSUB_S:  op_next = OP_FSUB_S;
          F7_FMUL_S:  op_next = OP_FMUL_S;
          F7_FDIV_S:  op_next = OP_FDIV_S;
          F7_FSQRT_S: op_next = OP_FSQRT_S;
          F7_FSGNJ_S: begin
            case (f3)
              3'd0:    op_next = OP_FSGNJ_S;
              3'd1:    op_next = OP_FSGNJN_S;
              3'd2:    op_next = OP_FSGNJX_S;
              default: op_next = OP_NONE;
            endcase
          end
          F7_FMINMAX_S: begin
            case (f3)
              3'd0:    op_next = OP_FMIN_S;
              3'd1:    op_next = OP_FMAX_S;
              default: op_next = OP_NONE;
            endcase
          end
          F7_FCVT_W_S: op_next = b20 ? OP_FCVT_WU_S : OP_FCVT_W_S;
          F7_FMV_X_W: begin
            case (f3)
              3'd0:    op_next = OP_FMV_X_W;
              3'd1:    op_next = OP_FCLASS_S;
              default: op_next = OP_NONE;
            endcase
          end
          F7_FCMP_S: begin
            case (f3)
              3'd0:    op_next = OP_FLE_S;
              3'd1:    op_next = OP_FLT_S;
              3'd2:    op_next = OP_FEQ_S;
              default: op_next = OP_NONE;
            endcase
          end
          F7_FCVT_S_W: op_next = b20 ? OP_FCVT_S_WU : OP_FCVT_S_W;
          F7_FMV_W_X:  op_next = OP_FMV_W_X;
          F7_FADD_D:   op_next = OP_FADD_D;
          F7_FSUB_D:   op_next = OP_FSUB_D;
          F7_FMUL_D:   op_next = OP_FMUL_D;
          F7_FDIV_D:   op_next = OP_FDIV_D;
          F7_FSQRT_D:  op_next = OP_FSQRT_D;
          F7_FSGNJ_D: begin
            case (f3)
              3'd0:    op_next = OP_FSGNJ_D;
              3'd1:    op_next = OP_FSGNJN_D;
              3'd2:    op_next = OP_FSGNJX_D;
              default: op_next = OP_NONE;
            endcase
          end
          F7_FMINMAX_D: begin
            case (f3)
              3'd0:    op_next = OP_FMIN_D;
              3'd1:    op_next = OP_FMAX_D;
              default: op_next = OP_NONE;
            endcase
          end
          F7_FCVT_S_D: op_next = OP_FCVT_S_D;
          F7_FCVT_D_S: op_next = OP_FCVT_D_S;
          F7_FCMP_D: begin
            case (f3)
              3'd0:    op_next = OP_FLE_D;
              3'd1:    op_next = OP_FLT_D;
              3'd2:    op_next = OP_FEQ_D;
              default: op_next = OP_NONE;
            endcase
          end
          F7_FCLASS_D: op_next = OP_FCLASS_D;
          F7_FCVT_W_D: op_next = b20 ? OP_FCVT_WU_D : OP_FCVT_W_D;
          F7_FCVT_D_W: op_next = b20 ? OP_FCVT_D_WU : OP_FCVT_D_W;
          default:     op_next = OP_NONE;
        endcase
      end
      default: begin
        op_next  = OP_NONE;
        fmt_next = FMT_N;
      end
    endcase
    // unmatched funct fields fall back to format N
    if (op_next == OP_NONE) begin
      fmt_next = FMT_N;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_axis_tready) begin
      valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      op   <= op_next;
      fmt  <= fmt_next;
      echo <= s_axis_tdata;
    end
  end

  assign m_axis_tvalid = valid;
  assign m_axis_tdata  = {{(OUT_W - INSN_W - 10){1'b0}}, echo, fmt, op};

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_fire_loads: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> valid && echo == $past(s_axis_tdata))
    else $error("accepted request not captured in result register");

  a_none_is_fmt_n: assert property (@(posedge clk) disable iff (rst)
    valid |-> ((op == OP_NONE) == (fmt == FMT_N)))
    else $error("operation index and format disagree on unrecognized word");

  a_r4_opcode: assert property (@(posedge clk) disable iff (rst)
    valid && fmt == FMT_R4 |-> echo[6:4] == 3'b100 && echo[1:0] == 2'b11)
    else $error("R4 format outside fused multiply-add opcodes");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    valid && !m_axis_tready |=> valid && $stable(op) && $stable(fmt))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !valid)
    else $error("result valid after reset");

endmodule
